@@ rtl/pbd_pkg.sv @@
// Shared types, codes and helpers for the capture-file block deframer.
package pbd_pkg;

	localparam logic [31:0] KIND_SHB        = 32'h0a0d0d0a;
	localparam logic [31:0] BYTE_ORDER_MARK = 32'h1a2b3c4d;
	localparam logic [31:0] KIND_EPB        = 32'h00000006;
	localparam logic [31:0] KIND_SPB        = 32'h00000003;

	localparam logic [31:0] EPB_DATA_AT = 32'd28;
	localparam logic [31:0] EPB_MIN_LEN = 32'd32;
	localparam logic [31:0] EPB_CAP_END = 32'd23;
	localparam logic [31:0] SPB_DATA_AT = 32'd12;
	localparam logic [31:0] SPB_MIN_LEN = 32'd20;
	localparam logic [31:0] SPB_CAP_END = 32'd11;
	localparam logic [31:0] MIN_BLOCK   = 32'd12;

	localparam logic [31:0] OFF_KIND_END = 32'd3;
	localparam logic [31:0] OFF_LEN_END  = 32'd7;
	localparam logic [31:0] OFF_BOM_END  = 32'd11;

	localparam logic [2:0] ST_PAYLOAD    = 3'd0;
	localparam logic [2:0] ST_DONE_OK    = 3'd1;
	localparam logic [2:0] ST_NOT_PCAPNG = 3'd2;
	localparam logic [2:0] ST_TRUNCATED  = 3'd3;
	localparam logic [2:0] ST_NO_PACKETS = 3'd4;

	typedef enum logic [1:0] {
		PH_FIRST = 2'd0,
		PH_RUN   = 2'd1,
		PH_STOP  = 2'd2,
		PH_BAD   = 2'd3
	} pbd_phase_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       packet_last;
		logic [2:0] status;
	} pbd_res_t;

	function automatic logic [31:0] swap32(input logic [31:0] v);
		return {v[7:0], v[15:8], v[23:16], v[31:24]};
	endfunction

endpackage

@@ rtl/pbd_in_if.sv @@
// Request channel carrying capture-file bytes.
interface pbd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_file;

	modport source (output valid, output in_byte, output end_of_file, input ready);
	modport sink (input valid, input in_byte, input end_of_file, output ready);
endinterface

@@ rtl/pbd_out_if.sv @@
// Request channel carrying extracted packet bytes and final status.
interface pbd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       packet_last;
	logic [2:0] status;

	modport source (output valid, output out_byte, output packet_last, output status,
		input ready);
	modport sink (input valid, input out_byte, input packet_last, input status,
		output ready);
endinterface

@@ rtl/pcapng_block_deframer_top.sv @@
// Capture-file block deframer: parses blocks byte by byte and emits packet payload.
//
// One capture byte is taken per cycle while input ready is high. Each accepted byte
// updates the block parser in the cycle it is taken and drops its results (a payload
// byte, a final status on the end-of-file byte, or both) into a QDEPTH-entry result
// queue that drains one result per cycle while the output is ready. Input ready is held
// low only while the queue has fewer than two free entries, so the sustained rate is one
// byte per cycle while the output is ready; an end-of-file byte inside a packet pushes
// two results. After it the parser is back in its reset state, ready for the next file.
module pcapng_block_deframer_top
	import pbd_pkg::*;
#(
	parameter int unsigned QDEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	pbd_in_if.sink           cap_in,
	pbd_out_if.source        pkt_out
);

	localparam int unsigned PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int unsigned CW = $clog2(QDEPTH + 1);

	// parser state
	logic [31:0] block_offset_q;
	logic [31:0] block_kind_q;
	logic [31:0] block_length_q;
	logic [31:0] cap_stop_q;
	logic        cap_ok_q;
	logic [31:0] word_q;
	logic        big_endian_q;
	pbd_phase_t  phase_q;
	logic        seen_packet_q;

	// result queue
	pbd_res_t    queue_q [QDEPTH];
	logic [PW-1:0] wptr_q;
	logic [PW-1:0] rptr_q;
	logic [CW-1:0] count_q;

	logic        acc;
	logic        pop;
	logic [7:0]  b;
	logic        eof;
	logic [31:0] w;
	logic [31:0] val;

	logic [31:0] off_n;
	logic [31:0] kind_n;
	logic [31:0] len_n;
	logic [31:0] stop_n;
	logic        cap_ok_n;
	logic        be_n;
	pbd_phase_t  phase_n;
	logic        seen_n;
	logic        emit;
	logic        emit_last;
	logic [31:0] data_at;
	logic [33:0] need;
	logic [2:0]  final_st;

	pbd_res_t    res0;
	pbd_res_t    res1;
	logic [1:0]  npush;
	logic [PW-1:0] wptr1;
	logic [PW-1:0] wptr2;
	logic [PW-1:0] rptr1;

	assign cap_in.ready = (count_q <= CW'(QDEPTH - 2));
	assign acc = cap_in.valid && cap_in.ready;
	assign pop = pkt_out.valid && pkt_out.ready;
	assign b   = cap_in.in_byte;
	assign eof = cap_in.end_of_file;
	assign w   = {b, word_q[31:8]};
	assign val = big_endian_q ? swap32(w) : w;

	always_comb begin
		off_n     = block_offset_q;
		kind_n    = block_kind_q;
		len_n     = block_length_q;
		stop_n    = cap_stop_q;
		cap_ok_n  = cap_ok_q;
		be_n      = big_endian_q;
		phase_n   = phase_q;
		seen_n    = seen_packet_q;
		emit      = 1'b0;
		emit_last = 1'b0;
		data_at   = SPB_DATA_AT;
		need      = '0;

		if (phase_q == PH_FIRST || phase_q == PH_RUN) begin
			if (block_offset_q == OFF_KIND_END) begin
				kind_n = val;
				if (phase_q == PH_FIRST && val != KIND_SHB)
					phase_n = PH_BAD;
			end
			if (phase_n != PH_BAD) begin
				if (block_offset_q == OFF_LEN_END) begin
					// section header length waits for its byte-order mark
					len_n = (kind_n == KIND_SHB) ? w : val;
					if (kind_n != KIND_SHB && val < MIN_BLOCK)
						phase_n = PH_STOP;
				end
				if (kind_n == KIND_SHB && block_offset_q == OFF_BOM_END) begin
					if (w == BYTE_ORDER_MARK)
						be_n = 1'b0;
					else if (swap32(w) == BYTE_ORDER_MARK)
						be_n = 1'b1;
					if (be_n)
						len_n = swap32(len_n);
					if (len_n < MIN_BLOCK)
						phase_n = PH_STOP;
					else if (phase_n == PH_FIRST)
						phase_n = PH_RUN;
				end
				if (kind_n == KIND_EPB && block_offset_q == EPB_CAP_END) begin
					need     = 34'(EPB_DATA_AT) + 34'(val) + 34'd4;
					cap_ok_n = (val != 32'd0) && (len_n >= EPB_MIN_LEN) &&
						(need <= {2'b00, len_n});
					stop_n   = EPB_DATA_AT + val;
				end
				if (kind_n == KIND_SPB && block_offset_q == SPB_CAP_END) begin
					need     = 34'(SPB_DATA_AT) + 34'(val) + 34'd4;
					cap_ok_n = (val != 32'd0) && (len_n >= SPB_MIN_LEN) &&
						(need <= {2'b00, len_n});
					stop_n   = SPB_DATA_AT + val;
				end
			end

			if (phase_n == PH_FIRST || phase_n == PH_RUN) begin
				data_at = (kind_n == KIND_EPB) ? EPB_DATA_AT : SPB_DATA_AT;
				if (cap_ok_n && (kind_n == KIND_EPB || kind_n == KIND_SPB) &&
					block_offset_q >= data_at && block_offset_q < stop_n) begin
					emit      = 1'b1;
					emit_last = (block_offset_q + 32'd1 == stop_n);
					seen_n    = 1'b1;
				end
				if (block_offset_q >= OFF_BOM_END &&
					({1'b0, block_offset_q} + 33'd1 == {1'b0, len_n})) begin
					off_n    = '0;
					kind_n   = '0;
					cap_ok_n = 1'b0;
				end else begin
					off_n = block_offset_q + 32'd1;
				end
			end
		end

		if (phase_n == PH_BAD || phase_n == PH_FIRST)
			final_st = ST_NOT_PCAPNG;
		else if (phase_n == PH_RUN && off_n != 32'd0)
			final_st = ST_TRUNCATED;
		else
			final_st = seen_n ? ST_DONE_OK : ST_NO_PACKETS;
	end

	always_comb begin
		res0.out_byte    = emit ? b : 8'd0;
		res0.packet_last = emit && emit_last;
		res0.status      = emit ? ST_PAYLOAD : final_st;
		res1.out_byte    = 8'd0;
		res1.packet_last = 1'b0;
		res1.status      = final_st;
		npush = acc ? ({1'b0, emit} + {1'b0, eof}) : 2'd0;
		wptr1 = (wptr_q == PW'(QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
		wptr2 = (wptr1 == PW'(QDEPTH - 1)) ? '0 : wptr1 + 1'b1;
		rptr1 = (rptr_q == PW'(QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_offset_q <= '0;
			block_kind_q   <= '0;
			block_length_q <= '0;
			cap_stop_q     <= '0;
			cap_ok_q       <= 1'b0;
			word_q         <= '0;
			big_endian_q   <= 1'b0;
			phase_q        <= PH_FIRST;
			seen_packet_q  <= 1'b0;
		end else if (acc) begin
			if (eof) begin
				block_offset_q <= '0;
				block_kind_q   <= '0;
				block_length_q <= '0;
				cap_stop_q     <= '0;
				cap_ok_q       <= 1'b0;
				word_q         <= '0;
				big_endian_q   <= 1'b0;
				phase_q        <= PH_FIRST;
				seen_packet_q  <= 1'b0;
			end else begin
				block_offset_q <= off_n;
				block_kind_q   <= kind_n;
				block_length_q <= len_n;
				cap_stop_q     <= stop_n;
				cap_ok_q       <= cap_ok_n;
				if (phase_q == PH_FIRST || phase_q == PH_RUN)
					word_q <= w;
				big_endian_q   <= be_n;
				phase_q        <= phase_n;
				seen_packet_q  <= seen_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (npush != 2'd0)
			queue_q[wptr_q] <= res0;
		if (npush == 2'd2)
			queue_q[wptr1] <= res1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			case (npush)
				2'd1: wptr_q <= wptr1;
				2'd2: wptr_q <= wptr2;
				default: wptr_q <= wptr_q;
			endcase
			if (pop)
				rptr_q <= rptr1;
			count_q <= count_q + CW'(npush) - CW'(pop);
		end
	end

	assign pkt_out.valid       = (count_q != '0);
	assign pkt_out.out_byte    = queue_q[rptr_q].out_byte;
	assign pkt_out.packet_last = queue_q[rptr_q].packet_last;
	assign pkt_out.status      = queue_q[rptr_q].status;

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QDEPTH))
		else $error("result queue overfilled");

	a_eof_rearm: assert property (@(posedge clk) disable iff (!arst_n)
		acc && eof |=> phase_q == PH_FIRST && block_offset_q == 32'd0 && !seen_packet_q)
		else $error("parser not rearmed after end of file");

	a_emit_running: assert property (@(posedge clk) disable iff (!arst_n)
		acc && emit |-> phase_q == PH_RUN && cap_ok_n)
		else $error("payload emitted outside a running packet block");

	a_status_clean: assert property (@(posedge clk) disable iff (!arst_n)
		pkt_out.valid && pkt_out.status != ST_PAYLOAD |->
			pkt_out.out_byte == 8'd0 && !pkt_out.packet_last)
		else $error("status result carries payload bits");

endmodule
